// ----- rtl/utf8_stream_decoder_defines.svh -----
// Assertion macros for the UTF-8 stream decoder checker.
// Self-contained; included by the checker file only.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define U8SD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8sd checker: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8sd checker: next-cycle property failed");

`endif

// ----- rtl/u8sd_pkg.sv -----
// Package for the UTF-8 stream decoder: byte classes, constants, result struct.
// No dependencies.
`timescale 1ns / 1ps

package u8sd_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned CntW = 3;

  localparam logic [7:0] AsciiMax  = 8'h7F;
  localparam logic [7:0] Lead2Min  = 8'hC0;
  localparam logic [7:0] Lead2Max  = 8'hDF;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] Lead3Max  = 8'hEF;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [7:0] Lead4Max  = 8'hF7;
  localparam logic [7:0] ContMask  = 8'h3F;
  localparam logic [7:0] Lead2Mask = 8'h1F;
  localparam logic [7:0] Lead3Mask = 8'h0F;
  localparam logic [7:0] Lead4Mask = 8'h07;

  typedef enum logic [2:0] {
    BC_ASCII,
    BC_LEAD2,
    BC_LEAD3,
    BC_LEAD4,
    BC_CONT
  } byte_class_t;

  typedef struct packed {
    logic            emit;
    logic [CpW-1:0]  code_point;
    logic [CntW-1:0] byte_count;
  } u8sd_result_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    if (b <= AsciiMax) begin
      c = BC_ASCII;
    end else if (b >= Lead2Min && b <= Lead2Max) begin
      c = BC_LEAD2;
    end else if (b >= Lead3Min && b <= Lead3Max) begin
      c = BC_LEAD3;
    end else if (b >= Lead4Min && b <= Lead4Max) begin
      c = BC_LEAD4;
    end else begin
      c = BC_CONT;
    end
    return c;
  endfunction

endpackage

// ----- rtl/u8sd_in_reg.sv -----
// Input register stage: holds one accepted byte until the decoder consumes it.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module u8sd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= data_byte;
    end
  end

endmodule

// ----- rtl/u8sd_decode.sv -----
// Decode state (owed count, sequence length, partial value) and per-byte update.
// Uses u8sd_pkg for byte classes and the result struct.
`timescale 1ns / 1ps

module u8sd_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            held_byte,
  output u8sd_pkg::u8sd_result_t result
);

  logic [1:0]                  bytes_owed, bytes_owed_next;
  logic [u8sd_pkg::CntW-1:0]   sequence_length, sequence_length_next;
  logic [u8sd_pkg::CpW-1:0]    partial_value, partial_value_next;
  logic [u8sd_pkg::CpW-1:0]    shifted;

  assign shifted = {partial_value[u8sd_pkg::CpW-7:0], held_byte[5:0] & u8sd_pkg::ContMask[5:0]};

  always_comb begin
    bytes_owed_next      = bytes_owed;
    sequence_length_next = sequence_length;
    partial_value_next   = partial_value;
    result.emit          = 1'b0;
    result.code_point    = '0;
    result.byte_count    = '0;
    case (u8sd_pkg::classify(held_byte))
      u8sd_pkg::BC_ASCII: begin
        result.emit       = 1'b1;
        result.code_point = {{(u8sd_pkg::CpW-8){1'b0}}, held_byte};
        result.byte_count = u8sd_pkg::CntW'(1);
      end
      u8sd_pkg::BC_LEAD2: begin
        bytes_owed_next      = 2'd1;
        sequence_length_next = u8sd_pkg::CntW'(2);
        partial_value_next   = {{(u8sd_pkg::CpW-8){1'b0}}, held_byte & u8sd_pkg::Lead2Mask};
      end
      u8sd_pkg::BC_LEAD3: begin
        bytes_owed_next      = 2'd2;
        sequence_length_next = u8sd_pkg::CntW'(3);
        partial_value_next   = {{(u8sd_pkg::CpW-8){1'b0}}, held_byte & u8sd_pkg::Lead3Mask};
      end
      u8sd_pkg::BC_LEAD4: begin
        bytes_owed_next      = 2'd3;
        sequence_length_next = u8sd_pkg::CntW'(4);
        partial_value_next   = {{(u8sd_pkg::CpW-8){1'b0}}, held_byte & u8sd_pkg::Lead4Mask};
      end
      u8sd_pkg::BC_CONT: begin
        if (bytes_owed != 2'd0) begin
          bytes_owed_next = bytes_owed - 2'd1;
          if (bytes_owed == 2'd1) begin
            result.emit          = 1'b1;
            result.code_point    = shifted;
            result.byte_count    = sequence_length;
            partial_value_next   = '0;
            sequence_length_next = '0;
          end else begin
            partial_value_next = shifted;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_owed      <= 2'd0;
      sequence_length <= '0;
      partial_value   <= '0;
    end else if (advance) begin
      bytes_owed      <= bytes_owed_next;
      sequence_length <= sequence_length_next;
      partial_value   <= partial_value_next;
    end
  end

endmodule

// ----- rtl/u8sd_out_reg.sv -----
// Result register: holds one decoded character until the consumer takes it.
// Uses u8sd_pkg for the result struct.
`timescale 1ns / 1ps

module u8sd_out_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  u8sd_pkg::u8sd_result_t     result,
  output logic                       can_take,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [u8sd_pkg::CpW-1:0]   code_point,
  output logic [u8sd_pkg::CntW-1:0]  byte_count
);

  logic load;

  assign can_take = !out_valid || out_ready;
  assign load     = advance && result.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point <= result.code_point;
      byte_count <= result.byte_count;
    end
  end

endmodule

// ----- rtl/utf8_stream_decoder.sv -----
// UTF-8 stream decoder: one byte per request in, one code point per finished character out.
// Accepted bytes wait in the input register; finished characters load the result register.
// Throughput: one byte per cycle; the input register drains whenever the result register
// is empty or being taken, so only a stalled consumer holds input back.
// Reset (rst, synchronous): clears both valid flags and the decode state; nothing owed.
// Depends on u8sd_pkg, u8sd_in_reg, u8sd_decode, u8sd_out_reg.
`timescale 1ns / 1ps

module utf8_stream_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [u8sd_pkg::CpW-1:0]   code_point,
  output logic [u8sd_pkg::CntW-1:0]  byte_count
);

  logic                   held_valid;
  logic [7:0]             held_byte;
  logic                   can_take;
  logic                   advance;
  u8sd_pkg::u8sd_result_t result;

  assign advance = held_valid && can_take;

  u8sd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  u8sd_decode u_dec (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .held_byte (held_byte),
    .result    (result)
  );

  u8sd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .result     (result),
    .can_take   (can_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .byte_count (byte_count)
  );

endmodule

// ----- rtl/u8sd_checker.sv -----
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
// Depends on utf8_stream_decoder_defines.svh and u8sd_pkg.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_defines.svh"

module u8sd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [7:0]                 data_byte,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [u8sd_pkg::CpW-1:0]   code_point,
  input logic [u8sd_pkg::CntW-1:0]  byte_count
);

  logic ascii_in;

  assign ascii_in = in_valid && in_ready && (data_byte <= u8sd_pkg::AsciiMax);

  `U8SD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(byte_count))
  `U8SD_ASSERT_NOW(a_count_range, clk, rst, out_valid, byte_count >= 3'd1 && byte_count <= 3'd4)
  `U8SD_ASSERT_NOW(a_one_byte_fits, clk, rst, out_valid && byte_count == 3'd1, code_point[u8sd_pkg::CpW-1:7] == '0)
  `U8SD_ASSERT_NEXT(a_ascii_emits, clk, rst, ascii_in && !out_valid, ##1 out_valid)

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for utf8_stream_decoder: byte requests in, decoded characters out.
// Randomly gapped driver and stalled sink; each character is checked against an in-bench decoder.
// Depends on u8sd_pkg and the utf8_stream_decoder RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int RandomBytes = 2000;
  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 16;

  typedef struct {
    logic [u8sd_pkg::CpW-1:0]  cp;
    logic [u8sd_pkg::CntW-1:0] cnt;
  } char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [u8sd_pkg::CpW-1:0] code_point;
  logic [u8sd_pkg::CntW-1:0] byte_count;

  logic [7:0] pending_bytes[$];
  char_t expected_chars[$];

  logic [1:0] owed_cont;
  logic [2:0] open_len;
  logic [u8sd_pkg::CpW-1:0] gathered_bits;

  int mismatches = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit in_taken = 1'b0;
  bit calm = 1'b0;

  utf8_stream_decoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .code_point(code_point),
    .byte_count(byte_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic queue_char(input char_t c);
    expected_chars.insert(expected_chars.size(), c);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    u8sd_pkg::byte_class_t kind;
    char_t c;
    if (b <= u8sd_pkg::AsciiMax) begin
      kind = u8sd_pkg::BC_ASCII;
    end else if (b >= u8sd_pkg::Lead2Min && b <= u8sd_pkg::Lead2Max) begin
      kind = u8sd_pkg::BC_LEAD2;
    end else if (b >= u8sd_pkg::Lead3Min && b <= u8sd_pkg::Lead3Max) begin
      kind = u8sd_pkg::BC_LEAD3;
    end else if (b >= u8sd_pkg::Lead4Min && b <= u8sd_pkg::Lead4Max) begin
      kind = u8sd_pkg::BC_LEAD4;
    end else begin
      kind = u8sd_pkg::BC_CONT;
    end
    case (kind)
      u8sd_pkg::BC_ASCII: begin
        c.cp = {{(u8sd_pkg::CpW-8){1'b0}}, b};
        c.cnt = 3'd1;
        queue_char(c);
      end
      u8sd_pkg::BC_LEAD2: begin
        owed_cont = 2'd1;
        open_len = 3'd2;
        gathered_bits = {{(u8sd_pkg::CpW-8){1'b0}}, b & u8sd_pkg::Lead2Mask};
      end
      u8sd_pkg::BC_LEAD3: begin
        owed_cont = 2'd2;
        open_len = 3'd3;
        gathered_bits = {{(u8sd_pkg::CpW-8){1'b0}}, b & u8sd_pkg::Lead3Mask};
      end
      u8sd_pkg::BC_LEAD4: begin
        owed_cont = 2'd3;
        open_len = 3'd4;
        gathered_bits = {{(u8sd_pkg::CpW-8){1'b0}}, b & u8sd_pkg::Lead4Mask};
      end
      default: begin
        // stray continuation is dropped
        if (owed_cont != 2'd0) begin
          gathered_bits = {gathered_bits[u8sd_pkg::CpW-7:0], b[5:0]};
          owed_cont = owed_cont - 2'd1;
          if (owed_cont == 2'd0) begin
            c.cp = gathered_bits;
            c.cnt = open_len;
            queue_char(c);
            gathered_bits = '0;
            open_len = 3'd0;
          end
        end
      end
    endcase
  endtask

  function automatic int pick_idle(input int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) begin
      return 0;
    end else if (r < 94) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, long_max);
  endfunction

  // request side: acceptance and prediction
  always @(posedge clk) begin
    cycles++;
    in_taken = !rst && in_valid && in_ready;
    if (in_taken) begin
      decode_byte(data_byte);
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        in_valid <= 1'b1;
        data_byte <= pending_bytes.pop_front();
        if ($urandom_range(0, 99) == 0) begin
          calm = !calm;
        end
        gap_left = pick_idle(30);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_idle(40);
    end
  end

  always @(posedge clk) begin : char_monitor
    char_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character, code_point", code_point, 0);
      end else begin
        want = expected_chars.pop_front();
        if (code_point !== want.cp) begin
          report_mismatch("code_point", code_point, want.cp);
        end
        if (byte_count !== want.cnt) begin
          report_mismatch("byte_count", byte_count, want.cnt);
        end
      end
    end
  end

  initial begin
    int len;
    int total;
    owed_cont = 2'd0;
    open_len = 3'd0;
    gathered_bits = '0;
    // stray first bytes, ASCII extremes, lead/continuation extremes, full-length chars,
    // interrupted sequence, ASCII inside a sequence, 0xF8..0xFF as continuation
    pending_bytes = '{8'h80, 8'hFF, 8'h00, 8'h7F, 8'hC0, 8'hBF, 8'hE2, 8'h82, 8'hAC,
                      8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                      8'hE2, 8'h82, 8'hDF, 8'hA9, 8'hE2, 8'h41, 8'h82, 8'hAC, 8'hC3,
                      8'hFA};
    total = pending_bytes.size() + RandomBytes;
    while (pending_bytes.size() < total) begin
      if ($urandom_range(0, 3) != 0) begin
        len = $urandom_range(1, 4);
        case (len)
          1: queue_byte(8'($urandom_range(0, u8sd_pkg::AsciiMax)));
          2: queue_byte(8'($urandom_range(u8sd_pkg::Lead2Min, u8sd_pkg::Lead2Max)));
          3: queue_byte(8'($urandom_range(u8sd_pkg::Lead3Min, u8sd_pkg::Lead3Max)));
          default: queue_byte(8'($urandom_range(u8sd_pkg::Lead4Min, u8sd_pkg::Lead4Max)));
        endcase
        for (int i = 1; i < len; i++) begin
          queue_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
      end else begin
        queue_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
    while (expected_chars.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
